>>> design/fca_pkg.sv
// ----------------------------------------------------------------------------
// FAT chain allocator package
// Shared codes, command/status bundles and result record.
// ----------------------------------------------------------------------------
package fca_pkg;

  localparam int CFG_W      = 10;
  localparam int LEN_W      = 17;
  localparam int IDX_PORT_W = 10;

  localparam logic [CFG_W-1:0] FDB_RESET = 10'd65;

  typedef enum logic [1:0] {
    OP_FORMAT = 2'd0,
    OP_FREE   = 2'd1,
    OP_WRITE  = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOT_FMT  = 2'd1,
    ST_NO_SPACE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    KIND_LINK = 2'd0,
    KIND_FREE = 2'd1,
    KIND_END  = 2'd2,
    KIND_RSVD = 2'd3
  } kind_e;

  typedef struct packed {
    logic load;
    logic fmt_init;
    logic fmt_step;
    logic rel_rd;
    logic rel_wr;
    logic rel_first;
    logic scan;
    logic take;
    logic link;
    logic rd_entry;
  } dp_cmd_t;

  typedef struct packed {
    logic  cur_ok;
    logic  cur_lt_n;
    kind_e rd_kind;
    logic  fmt_last;
    logic  found;
    logic  exhausted;
    logic  rem_zero;
    logic  have;
  } dp_stat_t;

  typedef struct packed {
    status_e               status;
    logic [IDX_PORT_W-1:0] head_block;
    logic                  first_valid;
    kind_e                 kind;
    logic [IDX_PORT_W-1:0] next;
  } result_t;

endpackage

>>> design/fca_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fca_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> design/fca_datapath.sv
// ----------------------------------------------------------------------------
// FAT chain allocator datapath
// Allocation table, walk/scan pointers, byte countdown and config register.
// ----------------------------------------------------------------------------
module fca_datapath
  import fca_pkg::*;
#(
  parameter int NUM_BLOCKS  = 1024,
  parameter int BLOCK_BYTES = 128
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  input  logic [IDX_PORT_W-1:0] start_block_i,
  input  logic [LEN_W-1:0]      byte_length_i,
  input  dp_cmd_t               cmd_i,
  output dp_stat_t              stat_o,
  output logic [IDX_PORT_W-1:0] first_block_o,
  output logic [IDX_PORT_W-1:0] entry_next_o
);

  localparam int IDX_W = $clog2(NUM_BLOCKS);
  localparam int CW    = ((IDX_W > IDX_PORT_W) ? IDX_W : IDX_PORT_W) + 1;
  localparam int ENT_W = IDX_W + 2;
  localparam logic [CW-1:0]    NB = CW'(NUM_BLOCKS);
  localparam logic [LEN_W-1:0] BB = LEN_W'(BLOCK_BYTES);

  logic [CFG_W-1:0] fdb_q;
  logic [CW-1:0]    cur_q, cur_d;
  logic [CW-1:0]    ptr_q, ptr_d;
  logic             pend_q, pend_d;
  logic             have_q, have_d;
  logic [IDX_W-1:0] pend_addr_q, pend_addr_d;
  logic [IDX_W-1:0] found_q, found_d;
  logic [IDX_W-1:0] prev_q, prev_d;
  logic [IDX_W-1:0] first_q, first_d;
  logic [LEN_W-1:0] rem_q, rem_d;

  logic             we, re;
  logic [IDX_W-1:0] waddr, raddr;
  logic [ENT_W-1:0] wdata, rdata;
  kind_e            rd_kind;
  logic [IDX_W-1:0] rd_next;
  logic [CW-1:0]    fdb_ext;
  logic             cur_ok, cur_lt_n, ptr_lt_n;

  fca_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NUM_BLOCKS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rd_kind  = kind_e'(rdata[IDX_W +: 2]);
  assign rd_next  = rdata[IDX_W-1:0];
  assign fdb_ext  = CW'(fdb_q);
  assign cur_lt_n = (cur_q < NB);
  assign cur_ok   = cur_lt_n && (cur_q >= fdb_ext);
  assign ptr_lt_n = (ptr_q < NB);

  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = cur_q[IDX_W-1:0];
    raddr = cur_q[IDX_W-1:0];
    wdata = '0;
    if (cmd_i.fmt_step) begin
      we    = 1'b1;
      waddr = ptr_q[IDX_W-1:0];
      wdata = {((ptr_q < fdb_ext) ? KIND_RSVD : KIND_FREE), {IDX_W{1'b0}}};
    end
    if (cmd_i.rel_rd) begin
      re = cur_ok;
    end
    if (cmd_i.rel_wr) begin
      we    = 1'b1;
      wdata = {KIND_FREE, {IDX_W{1'b0}}};
    end
    if (cmd_i.scan) begin
      re    = ptr_lt_n;
      raddr = ptr_q[IDX_W-1:0];
    end
    if (cmd_i.take) begin
      we    = 1'b1;
      waddr = pend_addr_q;
      wdata = {KIND_END, {IDX_W{1'b0}}};
    end
    if (cmd_i.link) begin
      we    = have_q;
      waddr = prev_q;
      wdata = {KIND_LINK, found_q};
    end
    if (cmd_i.rd_entry) begin
      re = cur_lt_n;
    end
  end

  always_comb begin
    cur_d       = cur_q;
    ptr_d       = ptr_q;
    pend_d      = pend_q;
    have_d      = have_q;
    pend_addr_d = pend_addr_q;
    found_d     = found_q;
    prev_d      = prev_q;
    first_d     = first_q;
    rem_d       = rem_q;
    if (cmd_i.load) begin
      cur_d  = CW'(start_block_i);
      ptr_d  = fdb_ext;
      rem_d  = byte_length_i;
      pend_d = 1'b0;
      have_d = 1'b0;
    end
    if (cmd_i.fmt_init) begin
      ptr_d = '0;
    end
    if (cmd_i.fmt_step) begin
      ptr_d = ptr_q + CW'(1);
    end
    if (cmd_i.rel_wr) begin
      cur_d = CW'(rd_next);
    end
    if (cmd_i.rel_first) begin
      cur_d = CW'(first_q);
    end
    if (cmd_i.scan) begin
      pend_d = ptr_lt_n;
      if (ptr_lt_n) begin
        pend_addr_d = ptr_q[IDX_W-1:0];
        ptr_d       = ptr_q + CW'(1);
      end
    end
    if (cmd_i.take) begin
      found_d = pend_addr_q;
      ptr_d   = CW'(pend_addr_q) + CW'(1);
      pend_d  = 1'b0;
      rem_d   = (rem_q > BB) ? (rem_q - BB) : '0;
    end
    if (cmd_i.link) begin
      if (!have_q) begin
        first_d = found_q;
      end
      prev_d = found_q;
      have_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fdb_q  <= FDB_RESET;
      pend_q <= 1'b0;
      have_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        fdb_q <= cfg_wdata_i;
      end
      pend_q <= pend_d;
      have_q <= have_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q       <= cur_d;
    ptr_q       <= ptr_d;
    pend_addr_q <= pend_addr_d;
    found_q     <= found_d;
    prev_q      <= prev_d;
    first_q     <= first_d;
    rem_q       <= rem_d;
  end

  assign stat_o.cur_ok    = cur_ok;
  assign stat_o.cur_lt_n  = cur_lt_n;
  assign stat_o.rd_kind   = rd_kind;
  assign stat_o.fmt_last  = (ptr_q == (NB - CW'(1)));
  assign stat_o.found     = pend_q && (rd_kind == KIND_FREE);
  assign stat_o.exhausted = !pend_q && !ptr_lt_n;
  assign stat_o.rem_zero  = (rem_q == '0);
  assign stat_o.have      = have_q;

  assign first_block_o = IDX_PORT_W'(first_q);
  assign entry_next_o  = IDX_PORT_W'(rd_next);

endmodule

>>> design/fca_controller.sv
// ----------------------------------------------------------------------------
// FAT chain allocator controller
// Sequences format, chain walks, first-fit scan and entry reads.
// ----------------------------------------------------------------------------
module fca_controller
  import fca_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            operation_i,
  input  logic                  start_valid_i,
  input  dp_stat_t              stat_i,
  input  logic [IDX_PORT_W-1:0] first_block_i,
  input  logic [IDX_PORT_W-1:0] entry_next_i,
  output dp_cmd_t               cmd_o,
  output logic                  done_o,
  output result_t               res_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_FMT,
    S_REL_RD,
    S_REL_WR,
    S_WALK_END,
    S_ALLOC,
    S_SCAN,
    S_LINK,
    S_RD,
    S_RD_WT
  } state_e;

  typedef enum logic [1:0] {
    RET_FREE,
    RET_ALLOC,
    RET_NOSPACE
  } ret_e;

  state_e  state_q;
  ret_e    ret_q;
  logic    formatted_q;
  logic    done_q;
  result_t res_q;
  op_e     op;

  assign op     = op_e'(operation_i);
  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.load     = start;
        cmd_o.fmt_init = start && (op == OP_FORMAT);
      end
      S_FMT:    cmd_o.fmt_step = 1'b1;
      S_REL_RD: cmd_o.rel_rd   = 1'b1;
      S_REL_WR: cmd_o.rel_wr   = 1'b1;
      S_SCAN: begin
        if (stat_i.found) begin
          cmd_o.take = 1'b1;
        end else if (stat_i.exhausted) begin
          cmd_o.rel_first = stat_i.have;
        end else begin
          cmd_o.scan = 1'b1;
        end
      end
      S_LINK: cmd_o.link     = 1'b1;
      S_RD:   cmd_o.rd_entry = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= RET_FREE;
      formatted_q <= 1'b0;
      done_q      <= 1'b0;
      res_q       <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            res_q <= '0;
            if (op == OP_FORMAT) begin
              state_q <= S_FMT;
            end else if (!formatted_q) begin
              res_q.status <= ST_NOT_FMT;
              done_q       <= 1'b1;
            end else begin
              unique case (op)
                OP_FREE: begin
                  ret_q   <= RET_FREE;
                  state_q <= S_REL_RD;
                end
                OP_WRITE: begin
                  ret_q   <= RET_ALLOC;
                  state_q <= start_valid_i ? S_REL_RD : S_ALLOC;
                end
                default: state_q <= S_RD;
              endcase
            end
          end
        end
        S_FMT: begin
          if (stat_i.fmt_last) begin
            formatted_q <= 1'b1;
            done_q      <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        S_REL_RD: begin
          state_q <= stat_i.cur_ok ? S_REL_WR : S_WALK_END;
        end
        S_REL_WR: begin
          state_q <= (stat_i.rd_kind == KIND_LINK) ? S_REL_RD : S_WALK_END;
        end
        S_WALK_END: begin
          unique case (ret_q)
            RET_ALLOC: state_q <= S_ALLOC;
            RET_NOSPACE: begin
              res_q.status <= ST_NO_SPACE;
              done_q       <= 1'b1;
              state_q      <= S_IDLE;
            end
            default: begin
              done_q  <= 1'b1;
              state_q <= S_IDLE;
            end
          endcase
        end
        S_ALLOC: begin
          if (stat_i.rem_zero) begin
            res_q.first_valid <= stat_i.have;
            res_q.head_block  <= stat_i.have ? first_block_i : '0;
            done_q            <= 1'b1;
            state_q           <= S_IDLE;
          end else begin
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (stat_i.found) begin
            state_q <= S_LINK;
          end else if (stat_i.exhausted) begin
            if (stat_i.have) begin
              ret_q   <= RET_NOSPACE;
              state_q <= S_REL_RD;
            end else begin
              res_q.status <= ST_NO_SPACE;
              done_q       <= 1'b1;
              state_q      <= S_IDLE;
            end
          end
        end
        S_LINK: state_q <= S_ALLOC;
        S_RD:   state_q <= S_RD_WT;
        S_RD_WT: begin
          if (stat_i.cur_lt_n) begin
            res_q.kind <= stat_i.rd_kind;
            res_q.next <= (stat_i.rd_kind == KIND_LINK) ? entry_next_i : '0;
          end else begin
            res_q.kind <= KIND_RSVD;
            res_q.next <= '0;
          end
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

>>> design/fat_chain_allocator_unit.sv
// Chain free: walks the chain, reading and then freeing each linked entry.
// Write chain: old-chain walk, first-fit scan of one entry per cycle, and a walk of the
// partial chain on no space.
// One item at a time: start is taken only while busy is low; done_o pulses 1 cycle.
// Reset clears the controller and formatted flag and sets the first data block to 65; table undefined until format.
// ----------------------------------------------------------------------------
// FAT chain allocator unit
// Allocation table with format, chain free, chain write and entry read.
// ----------------------------------------------------------------------------
module fat_chain_allocator_unit
  import fca_pkg::*;
#(
  parameter int NUM_BLOCKS  = 1024,
  parameter int BLOCK_BYTES = 128
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            operation_i,
  input  logic [IDX_PORT_W-1:0] start_block_i,
  input  logic                  start_valid_i,
  input  logic [LEN_W-1:0]      byte_length_i,
  output logic                  done_o,
  output logic [1:0]            status_o,
  output logic [IDX_PORT_W-1:0] first_block_o,
  output logic                  first_valid_o,
  output logic [1:0]            entry_kind_o,
  output logic [IDX_PORT_W-1:0] entry_next_o
);

  dp_cmd_t               cmd;
  dp_stat_t              stat;
  logic [IDX_PORT_W-1:0] dp_first;
  logic [IDX_PORT_W-1:0] dp_next;
  result_t               res;

  fca_controller u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .operation_i   (operation_i),
    .start_valid_i (start_valid_i),
    .stat_i        (stat),
    .first_block_i (dp_first),
    .entry_next_i  (dp_next),
    .cmd_o         (cmd),
    .done_o        (done_o),
    .res_o         (res)
  );

  fca_datapath #(
    .NUM_BLOCKS  (NUM_BLOCKS),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .start_block_i (start_block_i),
    .byte_length_i (byte_length_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .first_block_o (dp_first),
    .entry_next_o  (dp_next)
  );

  assign status_o      = res.status;
  assign first_block_o = res.head_block;
  assign first_valid_o = res.first_valid;
  assign entry_kind_o  = res.kind;
  assign entry_next_o  = res.next;

endmodule

>>> design/fca_checker.sv
// ----------------------------------------------------------------------------
// FAT chain allocator checker
// Port-level properties of the command handshake and result fields.
// ----------------------------------------------------------------------------
module fca_checker
  import fca_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  start,
  input logic                  busy,
  input logic                  done_o,
  input logic [1:0]            status_o,
  input logic [IDX_PORT_W-1:0] first_block_o,
  input logic                  first_valid_o,
  input logic [1:0]            entry_kind_o,
  input logic [IDX_PORT_W-1:0] entry_next_o
);

  a_idle_at_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result transfer while busy");

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy rose without an accepted command");

  a_valid_means_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && first_valid_o) |-> (status_o == ST_OK))
    else $error("chain reported with a failing status");

  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != ST_OK)) |->
      (!first_valid_o && (first_block_o == '0) && (entry_kind_o == KIND_LINK) &&
       (entry_next_o == '0)))
    else $error("failing result carries data");

  a_next_only_on_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (entry_kind_o != KIND_LINK)) |-> (entry_next_o == '0))
    else $error("next index on a non-link entry");

endmodule

bind fat_chain_allocator_unit fca_checker u_fca_checker (.*);
